@@ sv/oksr_pkg.sv @@
// Shared types and constants for the ordered key set rank block.
package oksr_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_W    = 60;
	localparam int RANK_W   = 11;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              dropped;
	} rsp_t;

	// Token walking the cell chain.
	typedef struct packed {
		logic             vld;
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] cnt;
		logic             hit;
		logic             placed;
		logic             dropped;
	} tok_t;

endpackage

@@ sv/oksr_cell.sv @@
// One storage cell of the key chain: holds a key, updates and forwards the passing token.
module oksr_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  oksr_pkg::tok_t prev,
	output oksr_pkg::tok_t next
);

	logic                       full_q;
	logic                       vld_q;
	logic [oksr_pkg::KEY_W-1:0] key_q;
	oksr_pkg::tok_t             tok_q;
	oksr_pkg::tok_t             tok_d;
	logic                       take;

	assign take = prev.vld && (prev.kind == oksr_pkg::KIND_INSERT) && !prev.dropped
		&& !prev.placed && !full_q;

	always_comb begin
		tok_d = prev;
		if (take) begin
			tok_d.placed = 1'b1;
		end
		if (prev.vld && (prev.kind == oksr_pkg::KIND_QUERY) && full_q) begin
			if (key_q >= prev.key) begin
				tok_d.cnt = prev.cnt + oksr_pkg::CNT_W'(1);
			end
			if (key_q == prev.key) begin
				tok_d.hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_q <= prev.vld;
			if (take) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take) begin
				key_q <= prev.key;
			end
			tok_q <= tok_d;
		end
	end

	always_comb begin
		next     = tok_q;
		next.vld = vld_q;
	end

endmodule

@@ sv/ordered_key_set_rank.sv @@
// Top level: ordered key multiset with descending-rank query, built as a chain of cells.
//
//  channel | payload             | handshake
//  req     | kind, key           | req_valid / req_stall
//  rsp     | rank, dropped       | rsp_valid / rsp_stall
//
// One item per cycle while rsp is not stalled; each beat's result passes through the register of
// every cell in the chain in turn, starting at the first, and then through the output register.
// Reset clears the occupancy count, all cell full flags and in-flight tokens.
// A stalled rsp beat freezes the whole chain; req_stall rises in the same cycle.
module ordered_key_set_rank (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  oksr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output oksr_pkg::rsp_t rsp
);

	logic                       adv;
	logic                       accept;
	logic                       full;
	logic [oksr_pkg::CNT_W-1:0] occ_q;
	logic                       rsp_valid_q;
	oksr_pkg::rsp_t             rsp_q;
	oksr_pkg::rsp_t             rsp_d;
	oksr_pkg::tok_t             tok [0:oksr_pkg::CAPACITY];

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;
	assign accept    = req_valid && adv;
	assign full      = (occ_q == oksr_pkg::CNT_W'(oksr_pkg::CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && (req.kind == oksr_pkg::KIND_INSERT) && !full) begin
			occ_q <= occ_q + oksr_pkg::CNT_W'(1);
		end
	end

	assign tok[0] = {req_valid, req.kind, req.key, {oksr_pkg::CNT_W{1'b0}}, 1'b0, 1'b0,
		(req.kind == oksr_pkg::KIND_INSERT) && full};

	for (genvar i = 0; i < oksr_pkg::CAPACITY; i++) begin : g_cell
		oksr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (tok[i]),
			.next   (tok[i+1])
		);
	end

	always_comb begin
		rsp_d.dropped = tok[oksr_pkg::CAPACITY].dropped;
		rsp_d.rank    = '0;
		if ((tok[oksr_pkg::CAPACITY].kind == oksr_pkg::KIND_QUERY)
			&& tok[oksr_pkg::CAPACITY].hit) begin
			rsp_d.rank = tok[oksr_pkg::CAPACITY].cnt[oksr_pkg::RANK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= tok[oksr_pkg::CAPACITY].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= oksr_pkg::CNT_W'(oksr_pkg::CAPACITY))
		else $error("occupancy above capacity");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped |-> full)
		else $error("drop reported while store not full");

	a_drop_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped |-> rsp.rank == '0)
		else $error("dropped insert with nonzero rank");

	a_frozen_occ: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(occ_q))
		else $error("occupancy moved while chain frozen");

endmodule
